// ----- sv/i2c_dac_address_program_sequencer_defines.svh -----
// Assertion macros for the address-program sequencer checker.
// The checker that uses them has ports named clock and reset.
`ifndef I2C_DAC_ADDRESS_PROGRAM_SEQUENCER_DEFINES_SVH
`define I2C_DAC_ADDRESS_PROGRAM_SEQUENCER_DEFINES_SVH

// same-cycle or overlapping property, reset masks the check
`define I2CDAP_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define I2CDAP_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/i2cdap_pkg.sv -----
package i2cdap_pkg;

   // tick counter and slot register widths
   localparam int TICK_COUNT_WIDTH = 16;
   localparam int SLOT_TICKS_WIDTH = 16;
   localparam int LIMIT_WIDTH =
      ((TICK_COUNT_WIDTH > SLOT_TICKS_WIDTH) ? TICK_COUNT_WIDTH : SLOT_TICKS_WIDTH) + 1;
   localparam logic [SLOT_TICKS_WIDTH-1:0] SLOT_TICKS_RESET = SLOT_TICKS_WIDTH'(500);

   // slot numbers inside a byte
   localparam logic [4:0] STEP_DATA_END  = 5'd24;  // first ACK slot
   localparam logic [4:0] STEP_ACK_HIGH  = 5'd25;  // ACK sampled here
   localparam logic [4:0] STEP_BYTE_LAST = 5'd26;
   localparam logic [4:0] STEP_LDAC_LAST = 5'd27;  // extra slot of byte 2
   localparam logic [4:0] STEP_LDAC_FALL = 5'd23;
   localparam logic [4:0] STEP_EDGE_LAST = 5'd2;   // START and STOP length - 1

   localparam logic [1:0] BYTE_LDAC_LOW  = 2'd1;
   localparam logic [1:0] BYTE_LDAC_HIGH = 2'd2;
   localparam logic [1:0] BYTE_FINAL     = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_START,
      PH_BYTE,
      PH_STOP
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [4:0] slot_step;
      logic [1:0] byte_number;
      logic [7:0] shift_byte;
   } seq_state_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic ldac;
   } pin_levels_type;

   // command byte n of the address-programming sequence
   function automatic logic [7:0] cmd_byte(input logic [1:0] n,
                                           input logic [2:0] cur_addr,
                                           input logic [2:0] new_addr);
      logic [7:0] b;
      case (n)
         2'd0:    b = 8'hC0 | {4'b0000, cur_addr, 1'b0};
         2'd1:    b = 8'h61 | {3'b000, cur_addr, 2'b00};
         2'd2:    b = 8'h62 | {3'b000, new_addr, 2'b00};
         default: b = 8'h63 | {3'b000, new_addr, 2'b00};
      endcase
      return b;
   endfunction

endpackage

// ----- sv/i2cdap_pins.sv -----
// Pin levels shown during the current slot
module i2cdap_pins (
   input  i2cdap_pkg::seq_state_type  state,
   output i2cdap_pkg::pin_levels_type pins
);
   import i2cdap_pkg::*;

   logic       scl_hi;
   logic [2:0] bit_idx;

   // bit index and SCL-high slot of a data bit (three slots per bit)
   always_comb begin
      scl_hi  = 1'b0;
      bit_idx = 3'd0;
      for (int k = 0; k < 8; k++) begin
         if (state.slot_step == 5'(3 * k + 1)) begin
            scl_hi = 1'b1;
         end
         if (state.slot_step >= 5'(3 * k) && state.slot_step < 5'(3 * k + 3)) begin
            bit_idx = 3'(k);
         end
      end
   end

   // levels per phase
   always_comb begin
      pins.scl  = 1'b1;
      pins.sda  = 1'b1;
      pins.ldac = 1'b1;
      case (state.phase)
         PH_START: begin
            pins.scl = (state.slot_step < STEP_EDGE_LAST);
            pins.sda = (state.slot_step == 5'd0);
         end
         PH_BYTE: begin
            if (state.slot_step < STEP_DATA_END) begin
               pins.sda = state.shift_byte[~bit_idx];  // MSB first
               pins.scl = scl_hi;
            end else begin
               pins.sda = 1'b1;
               pins.scl = (state.slot_step == STEP_ACK_HIGH);
            end
            if ((state.byte_number == BYTE_LDAC_LOW && state.slot_step >= STEP_LDAC_FALL) ||
                (state.byte_number == BYTE_LDAC_HIGH && state.slot_step <= STEP_BYTE_LAST)) begin
               pins.ldac = 1'b0;
            end
         end
         PH_STOP: begin
            pins.scl = (state.slot_step >= 5'd1);
            pins.sda = (state.slot_step == STEP_EDGE_LAST);
         end
         default: begin
            pins.scl  = 1'b1;
            pins.sda  = 1'b1;
            pins.ldac = 1'b1;
         end
      endcase
   end

endmodule

// ----- sv/i2c_dac_address_program_sequencer.sv -----
// Open-drain I2C master that sends the four-byte DAC address-programming
// command and drives LDAC. Each req word is one clock tick of the pin
// sequencer and yields one rsp word holding the pin levels, busy, done and
// the ACK flags (0 = ACK) for that tick. One word is taken per cycle while
// req_ready is high: the state update is a single registered pass, and an
// output register keeps req_ready high while a result waits (req_ready =
// output empty or being taken); rsp follows in the next cycle. csr_wr_data
// sets ticks per third-bit slot (0 acts as 1), in effect from the next tick.
module i2c_dac_address_program_sequencer (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_start_req,
   input  logic [2:0] req_current_bits,
   input  logic [2:0] req_new_bits,
   input  logic req_sda_in,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_scl_level,
   output logic rsp_sda_level,
   output logic rsp_ldac_level,
   output logic rsp_busy_res,
   output logic rsp_done_res,
   output logic [3:0] rsp_ack_flags,
   input  logic csr_wr_en,
   input  logic [i2cdap_pkg::SLOT_TICKS_WIDTH-1:0] csr_wr_data
);
   import i2cdap_pkg::*;

   // state registers
   logic [SLOT_TICKS_WIDTH-1:0] slot_ticks_ff;
   phase_type                   phase_ff, phase_in;
   logic [4:0]                  slot_step_ff, slot_step_in;
   logic [1:0]                  byte_number_ff, byte_number_in;
   logic [TICK_COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [2:0]                  cur_ff, cur_in;
   logic [2:0]                  new_ff, new_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [3:0]                  ack_ff, ack_in;

   // output register
   logic rsp_valid_ff;
   logic scl_ff, sda_ff, ldac_ff, busy_ff, done_ff;
   logic [3:0] ack_flags_ff;

   logic accept;
   logic start_now;
   seq_state_type  eff_state;
   pin_levels_type pins;
   logic [3:0] eff_ack;
   logic [TICK_COUNT_WIDTH-1:0] eff_tick;
   logic busy;
   logic done;
   logic slot_end;
   logic [4:0] last_step;
   logic [LIMIT_WIDTH-1:0] limit;
   logic [LIMIT_WIDTH-1:0] tick_plus;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign start_now = (phase_ff == PH_IDLE) && req_start_req;

   // state as seen by this tick, with the start request applied
   always_comb begin
      eff_state.phase       = phase_ff;
      eff_state.slot_step   = slot_step_ff;
      eff_state.byte_number = byte_number_ff;
      eff_state.shift_byte  = shift_ff;
      eff_tick              = tick_count_ff;
      eff_ack               = ack_ff;
      cur_in                = cur_ff;
      new_in                = new_ff;
      if (start_now) begin
         eff_state.phase       = PH_START;
         eff_state.slot_step   = 5'd0;
         eff_state.byte_number = 2'd0;
         eff_tick              = '0;
         eff_ack               = 4'hF;
         cur_in                = req_current_bits;
         new_in                = req_new_bits;
      end
   end

   i2cdap_pins u_pins (
      .state (eff_state),
      .pins  (pins)
   );

   // slot timing: saturates at the counter's full range
   assign busy      = (eff_state.phase != PH_IDLE);
   assign limit     = (slot_ticks_ff == '0) ? LIMIT_WIDTH'(1) : LIMIT_WIDTH'(slot_ticks_ff);
   assign tick_plus = LIMIT_WIDTH'(eff_tick) + LIMIT_WIDTH'(1);
   assign slot_end  = (tick_plus >= limit) || (&eff_tick);

   always_comb begin
      case (eff_state.phase)
         PH_BYTE:  last_step = (eff_state.byte_number == BYTE_LDAC_HIGH) ?
                               STEP_LDAC_LAST : STEP_BYTE_LAST;
         PH_START: last_step = STEP_EDGE_LAST;
         PH_STOP:  last_step = STEP_EDGE_LAST;
         default:  last_step = 5'd0;
      endcase
   end

   // next state
   always_comb begin
      phase_in       = eff_state.phase;
      slot_step_in   = eff_state.slot_step;
      byte_number_in = eff_state.byte_number;
      shift_in       = eff_state.shift_byte;
      tick_count_in  = eff_tick;
      ack_in         = eff_ack;
      done           = 1'b0;
      if (busy) begin
         if (slot_end) begin
            tick_count_in = '0;
            if (eff_state.phase == PH_BYTE && eff_state.slot_step == STEP_ACK_HIGH) begin
               ack_in[eff_state.byte_number] = req_sda_in;
            end
            if (eff_state.slot_step >= last_step) begin
               slot_step_in = 5'd0;
               case (eff_state.phase)
                  PH_START: begin
                     phase_in       = PH_BYTE;
                     byte_number_in = 2'd0;
                     shift_in       = cmd_byte(2'd0, cur_in, new_in);
                  end
                  PH_BYTE: begin
                     if (eff_state.byte_number == BYTE_FINAL) begin
                        phase_in = PH_STOP;
                     end else begin
                        byte_number_in = eff_state.byte_number + 2'd1;
                        shift_in       = cmd_byte(byte_number_in, cur_in, new_in);
                     end
                  end
                  default: begin
                     phase_in       = PH_IDLE;
                     byte_number_in = 2'd0;
                     done           = 1'b1;
                  end
               endcase
            end else begin
               slot_step_in = eff_state.slot_step + 5'd1;
            end
         end else begin
            tick_count_in = eff_tick + TICK_COUNT_WIDTH'(1);
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ticks_ff  <= SLOT_TICKS_RESET;
         phase_ff       <= PH_IDLE;
         slot_step_ff   <= '0;
         byte_number_ff <= '0;
         tick_count_ff  <= '0;
         cur_ff         <= '0;
         new_ff         <= '0;
         shift_ff       <= '0;
         ack_ff         <= 4'hF;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slot_ticks_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff       <= phase_in;
            slot_step_ff   <= slot_step_in;
            byte_number_ff <= byte_number_in;
            tick_count_ff  <= tick_count_in;
            cur_ff         <= cur_in;
            new_ff         <= new_in;
            shift_ff       <= shift_in;
            ack_ff         <= ack_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // result word payload
   always_ff @(posedge clock) begin
      if (accept) begin
         scl_ff       <= pins.scl;
         sda_ff       <= pins.sda;
         ldac_ff      <= pins.ldac;
         busy_ff      <= busy;
         done_ff      <= done;
         ack_flags_ff <= ack_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = scl_ff;
   assign rsp_sda_level  = sda_ff;
   assign rsp_ldac_level = ldac_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_ack_flags  = ack_flags_ff;

endmodule

// ----- sv/i2cdap_checker.sv -----
`include "i2c_dac_address_program_sequencer_defines.svh"

// Port-level checks on the sequencer
module i2cdap_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_scl_level,
   input logic rsp_sda_level,
   input logic rsp_ldac_level,
   input logic rsp_busy_res,
   input logic rsp_done_res
);

   // a waiting result word stays until taken
   `I2CDAP_CHECK_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")

   // an empty output register never stalls the input
   `I2CDAP_CHECK(a_ready_when_empty, !rsp_valid |-> req_ready, "req stalled while empty")

   // done only on a busy tick
   `I2CDAP_CHECK(a_done_busy, rsp_valid && rsp_done_res |-> rsp_busy_res, "done while idle")

   // idle ticks release every pin
   `I2CDAP_CHECK(a_idle_released,
      rsp_valid && !rsp_busy_res |-> rsp_scl_level && rsp_sda_level && rsp_ldac_level,
      "pin driven while idle")

endmodule

bind i2c_dac_address_program_sequencer i2cdap_checker u_i2cdap_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_scl_level  (rsp_scl_level),
   .rsp_sda_level  (rsp_sda_level),
   .rsp_ldac_level (rsp_ldac_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_done_res   (rsp_done_res)
);
